/* hdl/bmdb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constants for the biquad magnitude (dB) block.
// No dependencies; every other file imports this package.
package bmdb_pkg;

    localparam int COEF_W     = 32;
    localparam int RATE_W     = 19;
    localparam int FREQ_W     = 18;
    localparam int GAIN_W     = 19;
    localparam int PHASE_W    = 32;
    localparam int TRIG_W     = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = PHASE_W / DIV_BITS_PER_STAGE;

    localparam int TRIG_TERMS = 7;
    localparam int TRIG_LAT   = 2 * TRIG_TERMS + 3;

    localparam int LOG_FRAC = 20;
    localparam int LOG_W    = 28;
    localparam int LOG_LAT  = LOG_FRAC + 8;

    localparam int BACK_LAST  = TRIG_LAT + LOG_LAT + 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [31:0] HALF_PI_Q30   = 32'd1686629713;
    localparam logic [31:0] PHASE_MAX_Q32 = 32'd2104533975;
    localparam logic [31:0] TRIG_ONE      = 32'd1073741824;
    localparam logic signed [27:0] DB_PER_LOG2_Q24 = 28'sd50504453;
    localparam logic signed [GAIN_W-1:0] GAIN_FLOOR = -19'sd61440;
    localparam logic signed [GAIN_W-1:0] GAIN_CEIL  = 19'sd262143;

    localparam int SIN_DIV [TRIG_TERMS] = '{6, 20, 42, 72, 110, 156, 210};
    localparam int SIN_LOG [TRIG_TERMS] = '{3, 5, 6, 7, 7, 8, 8};
    localparam int COS_DIV [TRIG_TERMS] = '{2, 12, 30, 56, 90, 132, 182};
    localparam int COS_LOG [TRIG_TERMS] = '{1, 4, 5, 6, 7, 8, 8};

    typedef enum logic [2:0] {
        REG_NUM0 = 3'd0,
        REG_NUM1 = 3'd1,
        REG_NUM2 = 3'd2,
        REG_DEN0 = 3'd3,
        REG_DEN1 = 3'd4,
        REG_DEN2 = 3'd5,
        REG_RATE = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [COEF_W-1:0] num0;
        logic [COEF_W-1:0] num1;
        logic [COEF_W-1:0] num2;
        logic [COEF_W-1:0] den0;
        logic [COEF_W-1:0] den1;
        logic [COEF_W-1:0] den2;
        logic [RATE_W-1:0] rate;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               zero_rate;
    } phase_item_t;

endpackage

/* hdl/bmdb_cfg.sv */
`timescale 1ns / 1ps
// APB-style register file: six Q3.28 coefficients and the sample rate.
// Depends on bmdb_pkg.
module bmdb_cfg
    import bmdb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_reg_t sel;
    logic     wr;

    assign sel    = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num0 <= 32'd268435456;
            cfg_reg.num1 <= '0;
            cfg_reg.num2 <= '0;
            cfg_reg.den0 <= 32'd268435456;
            cfg_reg.den1 <= '0;
            cfg_reg.den2 <= '0;
            cfg_reg.rate <= 19'd48000;
        end
        else if (wr)
        begin
            unique case (sel)
                REG_NUM0: cfg_reg.num0 <= pwdata;
                REG_NUM1: cfg_reg.num1 <= pwdata;
                REG_NUM2: cfg_reg.num2 <= pwdata;
                REG_DEN0: cfg_reg.den0 <= pwdata;
                REG_DEN1: cfg_reg.den1 <= pwdata;
                REG_DEN2: cfg_reg.den2 <= pwdata;
                REG_RATE: cfg_reg.rate <= pwdata[RATE_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_NUM0: prdata = cfg_reg.num0;
            REG_NUM1: prdata = cfg_reg.num1;
            REG_NUM2: prdata = cfg_reg.num2;
            REG_DEN0: prdata = cfg_reg.den0;
            REG_DEN1: prdata = cfg_reg.den1;
            REG_DEN2: prdata = cfg_reg.den2;
            REG_RATE: prdata = CFG_DATA_W'(cfg_reg.rate);
            default:  prdata = '0;
        endcase
    end

endmodule

/* hdl/bmdb_front.sv */
`timescale 1ns / 1ps
// Front end: accept frequency beats, clamp, and form the Q32 phase with a
// pipelined radix-4 restoring divider. Depends on bmdb_pkg.
module bmdb_front
    import bmdb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RATE_W-1:0] rate,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FREQ_W-1:0] freq_hz,
    output logic              out_valid,
    input  logic              out_ready,
    output phase_item_t       out_item
);

    logic                vld_reg   [DIV_STAGES+1];
    logic [RATE_W-1:0]   rem_reg   [DIV_STAGES+1];
    logic [PHASE_W-1:0]  quo_reg   [DIV_STAGES+1];
    logic                clamp_reg [DIV_STAGES+1];
    logic                one_reg   [DIV_STAGES+1];
    logic                zr_reg    [DIV_STAGES+1];

    logic              en;
    logic [FREQ_W-1:0] f_eff;
    logic              clamp_next;

    assign en       = !vld_reg[DIV_STAGES] || out_ready;
    assign in_ready = en;
    assign f_eff    = (freq_hz == '0) ? FREQ_W'(1) : freq_hz;
    assign clamp_next = (freq_hz != '0) &&
                        ((25'(freq_hz) * 25'd100) > (25'(rate) * 25'd49));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= DIV_STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= RATE_W'(f_eff);
            quo_reg[0]   <= '0;
            clamp_reg[0] <= clamp_next;
            one_reg[0]   <= (rate == RATE_W'(1));
            zr_reg[0]    <= (rate == '0);
        end
    end

    for (genvar g = 1; g <= DIV_STAGES; g++)
    begin : g_div
        logic [RATE_W:0]  r1, r2, t1, t2;
        logic [RATE_W-1:0] rem_mid;
        logic             b1, b2;

        always_comb
        begin
            r1      = {rem_reg[g-1], 1'b0};
            b1      = (r1 >= {1'b0, rate});
            t1      = b1 ? (r1 - {1'b0, rate}) : r1;
            rem_mid = t1[RATE_W-1:0];
            r2      = {rem_mid, 1'b0};
            b2      = (r2 >= {1'b0, rate});
            t2      = b2 ? (r2 - {1'b0, rate}) : r2;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]   <= t2[RATE_W-1:0];
                quo_reg[g]   <= {quo_reg[g-1][PHASE_W-3:0], b1, b2};
                clamp_reg[g] <= clamp_reg[g-1];
                one_reg[g]   <= one_reg[g-1];
                zr_reg[g]    <= zr_reg[g-1];
            end
        end
    end

    assign out_valid          = vld_reg[DIV_STAGES];
    assign out_item.zero_rate = zr_reg[DIV_STAGES];
    assign out_item.phase     = clamp_reg[DIV_STAGES] ? PHASE_MAX_Q32 :
                                one_reg[DIV_STAGES]   ? '0 : quo_reg[DIV_STAGES];

endmodule

/* hdl/bmdb_fifo.sv */
`timescale 1ns / 1ps
// Short queue of phase beats between the front end and the back end.
// Depends on bmdb_pkg.
module bmdb_fifo
    import bmdb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  phase_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output phase_item_t out_item
);

    phase_item_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wptr_reg, rptr_reg;
    logic [FIFO_PTR_W:0]   cnt_reg;
    logic                  push, pop;

    assign in_ready  = (cnt_reg != FIFO_DEPTH[FIFO_PTR_W:0]);
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

endmodule

/* hdl/bmdb_trig.sv */
`timescale 1ns / 1ps
// Pipelined Q30 sine and cosine of a Q32 turn fraction: quadrant fold plus
// a seven-term Taylor series, one term per two stages. Depends on bmdb_pkg.
module bmdb_trig
    import bmdb_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [PHASE_W-1:0]       phase,
    output logic signed [TRIG_W-1:0] sin_q30,
    output logic signed [TRIG_W-1:0] cos_q30
);

    logic [31:0] x1_reg;
    logic [1:0]  q1_reg;
    logic [61:0] xprod;
    logic [63:0] x2prod;

    logic [31:0]        ts_reg [TRIG_TERMS+1];
    logic [31:0]        tc_reg [TRIG_TERMS+1];
    logic signed [33:0] s_reg  [TRIG_TERMS+1];
    logic signed [33:0] c_reg  [TRIG_TERMS+1];
    logic [31:0]        x2_reg [TRIG_TERMS+1];
    logic [1:0]         q_reg  [TRIG_TERMS+1];

    logic signed [TRIG_W-1:0] sin_reg, cos_reg;
    logic signed [33:0]       sf, cf;

    assign xprod  = 62'(phase[29:0]) * 62'(HALF_PI_Q30);
    assign x2prod = 64'(x1_reg) * 64'(x1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= xprod[61:30];
            q1_reg    <= phase[31:30];
            ts_reg[0] <= x1_reg;
            tc_reg[0] <= TRIG_ONE;
            s_reg[0]  <= signed'(34'(x1_reg));
            c_reg[0]  <= signed'(34'(TRIG_ONE));
            x2_reg[0] <= x2prod[61:30];
            q_reg[0]  <= q1_reg;
        end
    end

    for (genvar j = 0; j < TRIG_TERMS; j++)
    begin : g_term
        localparam int SSH = 32 + SIN_LOG[j];
        localparam int CSH = 32 + COS_LOG[j];
        localparam logic [65:0] SREC = ((66'd1 << SSH) / 66'(SIN_DIV[j])) + 66'd1;
        localparam logic [65:0] CREC = ((66'd1 << CSH) / 66'(COS_DIV[j])) + 66'd1;

        logic [31:0]        ps_reg, pc_reg, mx2_reg;
        logic signed [33:0] ms_reg, mc_reg;
        logic [1:0]         mq_reg;
        logic [63:0]        ps_prod, pc_prod;
        logic [65:0]        qs_prod, qc_prod;
        logic [31:0]        ts_new, tc_new;

        assign ps_prod = 64'(ts_reg[j]) * 64'(x2_reg[j]);
        assign pc_prod = 64'(tc_reg[j]) * 64'(x2_reg[j]);
        assign qs_prod = 66'(ps_reg) * SREC;
        assign qc_prod = 66'(pc_reg) * CREC;
        assign ts_new  = 32'(qs_prod >> SSH);
        assign tc_new  = 32'(qc_prod >> CSH);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ps_reg  <= ps_prod[61:30];
                pc_reg  <= pc_prod[61:30];
                mx2_reg <= x2_reg[j];
                ms_reg  <= s_reg[j];
                mc_reg  <= c_reg[j];
                mq_reg  <= q_reg[j];

                ts_reg[j+1] <= ts_new;
                tc_reg[j+1] <= tc_new;
                x2_reg[j+1] <= mx2_reg;
                q_reg[j+1]  <= mq_reg;
                if ((j % 2) == 0)
                begin
                    s_reg[j+1] <= ms_reg - signed'(34'(ts_new));
                    c_reg[j+1] <= mc_reg - signed'(34'(tc_new));
                end
                else
                begin
                    s_reg[j+1] <= ms_reg + signed'(34'(ts_new));
                    c_reg[j+1] <= mc_reg + signed'(34'(tc_new));
                end
            end
        end
    end

    assign sf = s_reg[TRIG_TERMS];
    assign cf = c_reg[TRIG_TERMS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (q_reg[TRIG_TERMS])
                2'd0:
                begin
                    sin_reg <= TRIG_W'(sf);
                    cos_reg <= TRIG_W'(cf);
                end
                2'd1:
                begin
                    sin_reg <= TRIG_W'(cf);
                    cos_reg <= TRIG_W'(-sf);
                end
                2'd2:
                begin
                    sin_reg <= TRIG_W'(-sf);
                    cos_reg <= TRIG_W'(-cf);
                end
                default:
                begin
                    sin_reg <= TRIG_W'(-cf);
                    cos_reg <= TRIG_W'(sf);
                end
            endcase
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

/* hdl/bmdb_log.sv */
`timescale 1ns / 1ps
// Pipelined Q20 log2 of re^2 + im^2 with a block exponent; one squaring
// stage per fraction bit. Depends on bmdb_pkg.
module bmdb_log
    import bmdb_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] re,
    input  logic signed [63:0] im,
    output logic [LOG_W-1:0]   log_q20,
    output logic               is_zero
);

    function automatic logic [6:0] bit_len(input logic [63:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

    logic [63:0] mr1_reg, mi1_reg;
    logic [63:0] mr2_reg, mi2_reg;
    logic [5:0]  sh2_reg;
    logic [30:0] a3_reg, b3_reg;
    logic [5:0]  sh3_reg;
    logic [61:0] aa4_reg, bb4_reg;
    logic [5:0]  sh4_reg;
    logic [62:0] sq5_reg;
    logic [5:0]  sh5_reg;
    logic        z5_reg;
    logic [62:0] sq6_reg;
    logic [5:0]  e6_reg, sh6_reg;
    logic        z6_reg;

    logic [30:0]         m_reg  [LOG_FRAC+1];
    logic [LOG_FRAC-1:0] fr_reg [LOG_FRAC+1];
    logic [7:0]          ip_reg [LOG_FRAC+1];
    logic                z_reg  [LOG_FRAC+1];

    logic [LOG_W-1:0] log_reg;
    logic             zero_reg;

    logic [6:0]  bl_mag, bl_sq;
    logic [5:0]  sh_next;
    logic [63:0] norm_dn, norm_up;

    assign bl_mag  = bit_len(mr1_reg | mi1_reg);
    assign sh_next = (bl_mag > 7'd31) ? 6'(bl_mag - 7'd31) : '0;
    assign bl_sq   = bit_len(64'(sq5_reg));
    assign norm_dn = 64'(sq6_reg) >> (e6_reg - 6'd30);
    assign norm_up = 64'(sq6_reg) << (6'd30 - e6_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mr1_reg <= (re < 0) ? 64'(-re) : 64'(re);
            mi1_reg <= (im < 0) ? 64'(-im) : 64'(im);

            mr2_reg <= mr1_reg;
            mi2_reg <= mi1_reg;
            sh2_reg <= sh_next;

            a3_reg  <= 31'(mr2_reg >> sh2_reg);
            b3_reg  <= 31'(mi2_reg >> sh2_reg);
            sh3_reg <= sh2_reg;

            aa4_reg <= 62'(a3_reg) * 62'(a3_reg);
            bb4_reg <= 62'(b3_reg) * 62'(b3_reg);
            sh4_reg <= sh3_reg;

            sq5_reg <= 63'(aa4_reg) + 63'(bb4_reg);
            z5_reg  <= (aa4_reg == '0) && (bb4_reg == '0);
            sh5_reg <= sh4_reg;

            sq6_reg <= sq5_reg;
            e6_reg  <= (bl_sq == '0) ? '0 : 6'(bl_sq - 7'd1);
            sh6_reg <= sh5_reg;
            z6_reg  <= z5_reg;

            m_reg[0]  <= (e6_reg > 6'd30) ? norm_dn[30:0] : norm_up[30:0];
            fr_reg[0] <= '0;
            ip_reg[0] <= 8'(e6_reg) + {1'b0, sh6_reg, 1'b0};
            z_reg[0]  <= z6_reg;
        end
    end

    for (genvar i = 1; i <= LOG_FRAC; i++)
    begin : g_sq
        logic [61:0] mm;
        logic [31:0] t;

        assign mm = 62'(m_reg[i-1]) * 62'(m_reg[i-1]);
        assign t  = mm[61:30];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[i]  <= t[31] ? t[31:1] : t[30:0];
                fr_reg[i] <= {fr_reg[i-1][LOG_FRAC-2:0], t[31]};
                ip_reg[i] <= ip_reg[i-1];
                z_reg[i]  <= z_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            log_reg  <= {ip_reg[LOG_FRAC], fr_reg[LOG_FRAC]};
            zero_reg <= z_reg[LOG_FRAC];
        end
    end

    assign log_q20 = log_reg;
    assign is_zero = zero_reg;

endmodule

/* hdl/bmdb_back.sv */
`timescale 1ns / 1ps
// Back end: trig of w and 2w, complex numerator and denominator sums,
// log2 of both magnitudes and the dB scaling. Depends on bmdb_pkg.
module bmdb_back
    import bmdb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  phase_item_t              in_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [GAIN_W-1:0] gain_db
);

    function automatic logic signed [63:0] smul(
        input logic signed [31:0] a,
        input logic signed [31:0] b
    );
        return a * b;
    endfunction

    logic               vld_reg [BACK_LAST+1];
    logic               zr_reg  [BACK_LAST];
    logic [PHASE_W-1:0] ph_reg;
    logic               en;

    logic signed [TRIG_W-1:0] s1, c1, s2, c2;
    logic signed [63:0] pb1c_reg, pb2c_reg, pb1s_reg, pb2s_reg;
    logic signed [63:0] pa1c_reg, pa2c_reg, pa1s_reg, pa2s_reg;
    logic signed [63:0] nr_reg, ni_reg, dr_reg, di_reg;
    logic signed [63:0] b0w, a0w;

    logic [LOG_W-1:0]   ln, ld;
    logic               nz, dz;
    logic signed [LOG_W:0] diff;
    logic signed [63:0] prod_reg;
    logic               nz_reg;
    logic signed [63:0] q8;
    logic signed [GAIN_W-1:0] gain_reg;

    assign en       = !vld_reg[BACK_LAST] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= BACK_LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= BACK_LAST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg    <= in_item.phase;
            zr_reg[0] <= in_item.zero_rate;
            for (int i = 1; i < BACK_LAST; i++)
            begin
                zr_reg[i] <= zr_reg[i-1];
            end
        end
    end

    bmdb_trig u_trig_w (
        .clk     (clk),
        .en      (en),
        .phase   (ph_reg),
        .sin_q30 (s1),
        .cos_q30 (c1)
    );

    bmdb_trig u_trig_2w (
        .clk     (clk),
        .en      (en),
        .phase   ({ph_reg[PHASE_W-2:0], 1'b0}),
        .sin_q30 (s2),
        .cos_q30 (c2)
    );

    assign b0w = 64'($signed(cfg.num0)) <<< 28;
    assign a0w = ($signed(cfg.den0) < 32'sd1) ? (64'sd1 <<< 28)
                                               : (64'($signed(cfg.den0)) <<< 28);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pb1c_reg <= smul($signed(cfg.num1), c1);
            pb2c_reg <= smul($signed(cfg.num2), c2);
            pb1s_reg <= smul($signed(cfg.num1), s1);
            pb2s_reg <= smul($signed(cfg.num2), s2);
            pa1c_reg <= smul($signed(cfg.den1), c1);
            pa2c_reg <= smul($signed(cfg.den2), c2);
            pa1s_reg <= smul($signed(cfg.den1), s1);
            pa2s_reg <= smul($signed(cfg.den2), s2);

            nr_reg <= b0w + (pb1c_reg >>> 2) + (pb2c_reg >>> 2);
            ni_reg <= -((pb1s_reg >>> 2) + (pb2s_reg >>> 2));
            dr_reg <= a0w + (pa1c_reg >>> 2) + (pa2c_reg >>> 2);
            di_reg <= -((pa1s_reg >>> 2) + (pa2s_reg >>> 2));
        end
    end

    bmdb_log u_log_num (
        .clk     (clk),
        .en      (en),
        .re      (nr_reg),
        .im      (ni_reg),
        .log_q20 (ln),
        .is_zero (nz)
    );

    bmdb_log u_log_den (
        .clk     (clk),
        .en      (en),
        .re      (dr_reg),
        .im      (di_reg),
        .log_q20 (ld),
        .is_zero (dz)
    );

    assign diff = signed'({1'b0, ln}) - (dz ? '0 : signed'({1'b0, ld}));
    assign q8   = (prod_reg + (64'sd1 <<< 35)) >>> 36;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 64'(diff) * 64'(DB_PER_LOG2_Q24);
            nz_reg   <= nz;

            if (zr_reg[BACK_LAST-1])
            begin
                gain_reg <= '0;
            end
            else if (nz_reg || (q8 < 64'(GAIN_FLOOR)))
            begin
                gain_reg <= GAIN_FLOOR;
            end
            else if (q8 > 64'(GAIN_CEIL))
            begin
                gain_reg <= GAIN_CEIL;
            end
            else
            begin
                gain_reg <= GAIN_W'(q8);
            end
        end
    end

    assign out_valid = vld_reg[BACK_LAST];
    assign gain_db   = gain_reg;

endmodule

/* hdl/biquad_magnitude_db_top.sv */
`timescale 1ns / 1ps
// Top level of the biquad magnitude response block: register port, front
// end, phase queue and back end. Depends on bmdb_pkg and all bmdb_ modules.
//
// Each beat on the input carries one frequency in hertz; each beat on the
// output carries 20*log10|H(e^jw)| of the configured biquad as signed Q10.8
// dB, in input order. The block takes one item per clock while out_ready
// stays high. An item passes through the front end (input register plus a
// 16-stage divider producing two phase bits per stage), the 4-entry phase
// queue and the back end (17 trig stages, products and sums, 28 log2 stages
// with one squaring per fraction bit, then dB scaling). Write the registers
// only while no item is in flight.
module biquad_magnitude_db_top
    import bmdb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0]    pwdata,
    output logic [CFG_DATA_W-1:0]    prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FREQ_W-1:0]        freq_hz,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [GAIN_W-1:0] gain_db
);

    cfg_t        cfg;
    phase_item_t fr_item, q_item;
    logic        fr_valid, fr_ready, q_valid, q_ready;

    bmdb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmdb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rate      (cfg.rate),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .freq_hz   (freq_hz),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    bmdb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    bmdb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .gain_db   (gain_db)
    );

endmodule

/* sim/biquad_magnitude_db_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for biquad_magnitude_db_top: drives frequencies through
// the valid/ready input, programs the APB registers between phases and checks each gain.
// Depends on bmdb_pkg and the block's RTL.
module biquad_magnitude_db_top_tb;
    import bmdb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int N_DIRECTED     = 12;
    localparam logic [FREQ_W-1:0] DIRECTED [N_DIRECTED] = '{
        18'd0, 18'd1, 18'd2, 18'd1000, 18'd12000, 18'd23519, 18'd23520, 18'd23521,
        18'd24000, 18'd65535, 18'd131072, 18'd262143
    };

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_W-1:0]    paddr;
    logic [CFG_DATA_W-1:0]    pwdata;
    logic [CFG_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_ready;
    logic [FREQ_W-1:0]        freq_hz;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [GAIN_W-1:0] gain_db;

    logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a0_q, a1_q, a2_q;
    logic [RATE_W-1:0]        fs_q;

    logic [FREQ_W-1:0]        freq_q[$];
    logic signed [GAIN_W-1:0] gain_q[$];
    int                       err_cnt;
    int                       idle_cycles;
    int                       in_gap;
    int                       out_stall;
    bit                       no_idle;

    biquad_magnitude_db_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .freq_hz   (freq_hz),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .gain_db   (gain_db)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void sin_cos(input bit [31:0] ph, output longint sn, output longint cs);
        bit [63:0] x, x2, ts, tc;
        longint    s, c;
        x  = ({34'd0, ph[29:0]} * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        s  = longint'(x);
        c  = longint'(tc);
        for (int k = 1; k <= 7; k++)
        begin
            ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
            begin
                s -= longint'(ts);
                c -= longint'(tc);
            end
            else
            begin
                s += longint'(ts);
                c += longint'(tc);
            end
        end
        case (ph[31:30])
            2'd0:    begin sn = s;  cs = c;  end
            2'd1:    begin sn = c;  cs = -s; end
            2'd2:    begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s;  end
        endcase
    endfunction

    function automatic longint log2_q20(input bit [63:0] v);
        int        e;
        bit [63:0] m;
        bit [63:0] frac;
        e    = 63;
        frac = 0;
        while (e > 0 && v[e] == 1'b0)
            e--;
        m = (e > 30) ? (v >> (e - 30)) : (v << (30 - e));
        for (int i = 0; i < LOG_FRAC; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return longint'(e) * (longint'(1) << LOG_FRAC) + longint'(frac);
    endfunction

    function automatic bit log2_power(input longint re, input longint im, output longint lg);
        bit [63:0] mr, mi, a, b, sq;
        int        s;
        mr = (re < 0) ? 64'(-re) : 64'(re);
        mi = (im < 0) ? 64'(-im) : 64'(im);
        s  = 0;
        while (((mr | mi) >> s) >= (64'd2 << 30))
            s++;
        a  = mr >> s;
        b  = mi >> s;
        sq = a * a + b * b;
        lg = 0;
        if (sq == 0)
            return 1'b0;
        lg = log2_q20(sq) + longint'(2 * s) * (longint'(1) << LOG_FRAC);
        return 1'b1;
    endfunction

    function automatic logic signed [GAIN_W-1:0] predict_gain_db(input logic [FREQ_W-1:0] f);
        bit [63:0] fw, fs, ph;
        longint    s1, c1, s2, c2, a0, nr, ni, dr, di, ln, ld, q8;
        longint    b0, b1, b2, a1, a2;
        fw = 64'(f);
        fs = 64'(fs_q);
        if (fs == 0)
            return '0;
        if (fw == 0)
            ph = (64'd1 << 32) / fs;
        else if (100 * fw > 49 * fs)
            ph = 64'(PHASE_MAX_Q32);
        else
            ph = (fw << 32) / fs;
        sin_cos(ph[31:0], s1, c1);
        sin_cos({ph[30:0], 1'b0}, s2, c2);
        b0 = longint'(b0_q);
        b1 = longint'(b1_q);
        b2 = longint'(b2_q);
        a1 = longint'(a1_q);
        a2 = longint'(a2_q);
        a0 = (longint'(a0_q) < 1) ? 1 : longint'(a0_q);
        nr = b0 * (longint'(1) << 28) + ((b1 * c1) >>> 2) + ((b2 * c2) >>> 2);
        ni = -(((b1 * s1) >>> 2) + ((b2 * s2) >>> 2));
        dr = a0 * (longint'(1) << 28) + ((a1 * c1) >>> 2) + ((a2 * c2) >>> 2);
        di = -(((a1 * s1) >>> 2) + ((a2 * s2) >>> 2));
        if (!log2_power(nr, ni, ln))
            return GAIN_FLOOR;
        if (!log2_power(dr, di, ld))
            ld = 0;
        q8 = ((ln - ld) * longint'(50504453) + (longint'(1) << 35)) >>> 36;
        if (q8 < longint'(GAIN_FLOOR))
            q8 = longint'(GAIN_FLOOR);
        if (q8 > longint'(GAIN_CEIL))
            q8 = longint'(GAIN_CEIL);
        return q8[GAIN_W-1:0];
    endfunction

    function automatic int draw_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NUM0: b0_q = val;
            REG_NUM1: b1_q = val;
            REG_NUM2: b2_q = val;
            REG_DEN0: a0_q = val;
            REG_DEN1: a1_q = val;
            REG_DEN2: a2_q = val;
            default:  fs_q = val[RATE_W-1:0];
        endcase
    endtask

    task automatic write_all(input logic [31:0] b0, input logic [31:0] b1,
                             input logic [31:0] b2, input logic [31:0] a0,
                             input logic [31:0] a1, input logic [31:0] a2,
                             input logic [31:0] fs);
        write_reg(REG_NUM0, b0);
        write_reg(REG_NUM1, b1);
        write_reg(REG_NUM2, b2);
        write_reg(REG_DEN0, a0);
        write_reg(REG_DEN1, a1);
        write_reg(REG_DEN2, a2);
        write_reg(REG_RATE, fs);
    endtask

    function automatic logic [31:0] rand_coef();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
        if (r < 6)
            return $urandom();
        if (r < 8)
            return 32'($signed($urandom_range(0, 32'h0FFF)) - 32'sh0800);
        return 32'h1000_0000;
    endfunction

    function automatic logic [FREQ_W-1:0] rand_freq();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 5)
            return FREQ_W'($urandom());
        if (fs_q == 0)
            return FREQ_W'($urandom());
        return FREQ_W'($urandom_range(1, (int'(fs_q) * 49) / 100 + 2));
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (freq_q.size() != 0 || gain_q.size() != 0 || in_valid)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            freq_hz  <= '0;
            in_gap   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                gain_q.push_back(predict_gain_db(freq_hz));
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (freq_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    freq_hz  <= freq_q.pop_front();
                    in_gap   = draw_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (gain_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected beat: gain_db=%0d", gain_db);
                end
                else
                begin
                    logic signed [GAIN_W-1:0] want;
                    want = gain_q.pop_front();
                    if (gain_db !== want)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("gain_db mismatch: expected %0d, got %0d", want, gain_db);
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall = draw_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        err_cnt     = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        b0_q = 32'h1000_0000; b1_q = '0; b2_q = '0;
        a0_q = 32'h1000_0000; a1_q = '0; a2_q = '0;
        fs_q = 19'd48000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            freq_q.push_back(DIRECTED[i]);
        wait_drained();

        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: write_all(0, 0, 0, 32'h1000_0000, 0, 0, 48000);
                1: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 384000);
                2: write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
                3: write_all(rand_coef(), rand_coef(), rand_coef(),
                             rand_coef(), rand_coef(), rand_coef(), 0);
                4: write_all(rand_coef(), rand_coef(), rand_coef(),
                             32'hFFFF_FF00, 0, 0, $urandom_range(1, 384000));
                5: write_all(32'h1000_0000, 32'hE000_0000, 32'h1000_0000,
                             32'h1000_0000, 32'hE000_0000, 32'h0F00_0000, 44100);
                6: write_all(32'h0800_0000, 32'h1000_0000, 32'h0800_0000,
                             32'h1000_0000, 32'h2000_0000, 32'h1000_0000, 8000);
                default: write_all(rand_coef(), rand_coef(), rand_coef(),
                                   rand_coef(), rand_coef(), rand_coef(),
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200)
                                                               : $urandom_range(1, 384000));
            endcase
            no_idle = (p % 4 == 3);
            for (int n = 0; n < 40; n++)
                freq_q.push_back(rand_freq());
            wait_drained();
        end

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
hdl/bmdb_pkg.sv
hdl/bmdb_cfg.sv
hdl/bmdb_front.sv
hdl/bmdb_fifo.sv
hdl/bmdb_trig.sv
hdl/bmdb_log.sv
hdl/bmdb_back.sv
hdl/biquad_magnitude_db_top.sv
sim/biquad_magnitude_db_top_tb.sv
